// File: hdl/pipeline_stall_timing_scoreboard_assert.svh
// Assertion macros shared by the scoreboard modules.
// Both expect clk and rst_n in the enclosing scope.
`ifndef PIPELINE_STALL_TIMING_SCOREBOARD_ASSERT_SVH
`define PIPELINE_STALL_TIMING_SCOREBOARD_ASSERT_SVH

// same-cycle implication
`define PST_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PST_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pst_pkg.sv
`timescale 1ns / 1ps
package pst_pkg;

    localparam int REG_COUNT  = 32;
    localparam int CYCLE_BITS = 32;
    localparam int IDX_W      = 5;
    localparam int REG_AW     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int OUT_W      = 32;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    localparam logic [6:0] OP_R      = 7'b0110011;
    localparam logic [6:0] OP_I      = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;

    localparam logic [2:0] CL_R       = 3'd0;
    localparam logic [2:0] CL_I       = 3'd1;
    localparam logic [2:0] CL_LOAD    = 3'd2;
    localparam logic [2:0] CL_STORE   = 3'd3;
    localparam logic [2:0] CL_BRANCH  = 3'd4;
    localparam logic [2:0] CL_LUI     = 3'd5;
    localparam logic [2:0] CL_AUIPC   = 3'd6;
    localparam logic [2:0] CL_UNKNOWN = 3'd7;

    typedef logic [CYCLE_BITS-1:0] cycle_t;
    localparam cycle_t CYC_MAX = '1;

    // classified item; src_a/src_b already swapped for stores
    typedef struct packed {
        logic [2:0]       cls;
        logic [IDX_W-1:0] rd;
        logic [IDX_W-1:0] src_a;
        logic [IDX_W-1:0] src_b;
        logic             wait_a;
        logic             wait_b;
        logic             wait_m;
        logic             wr;
    } item_t;

    typedef struct packed {
        logic [2:0]       cls;
        logic [OUT_W-1:0] fetch_cycle;
        logic [OUT_W-1:0] decode_cycle;
        logic [OUT_W-1:0] execute_cycle;
        logic [OUT_W-1:0] memory_cycle;
        logic [OUT_W-1:0] writeback_cycle;
        logic             ovf;
    } result_t;

    typedef struct packed {
        logic   ovf;
        cycle_t val;
    } sat_t;

endpackage

// File: hdl/pipeline_stall_timing_scoreboard.sv
`timescale 1ns / 1ps
// Channel   Dir  Width  Contents
// s_axis    in   32     instr_word
// m_axis    out  168    instr_class, fetch..writeback cycles, cycle_overflow
//
// The stage sequencer resolves one stage step per cycle and reads the
// register busy table through one port; it takes items only when idle.
// Input is taken while the sequencer works, up to three items buffered.
// Reset clears all stage history and the busy table valid bits at once.
// A stalled result holds the sequencer in its writeback step.
module pipeline_stall_timing_scoreboard (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // instr_word[31:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata    // instr_class[2:0], fetch_cycle[34:3],
                                    // decode_cycle[66:35], execute_cycle[98:67],
                                    // memory_cycle[130:99], writeback_cycle[162:131],
                                    // cycle_overflow[163], zero pad
);
    import pst_pkg::*;

    logic    fr_vld, fr_rdy, q_vld, q_rdy;
    item_t   fr_item, q_item;
    result_t res;

    pst_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_vld     (s_tvalid),
        .in_rdy     (s_tready),
        .instr_word (s_tdata),
        .out_vld    (fr_vld),
        .out_rdy    (fr_rdy),
        .out_item   (fr_item)
    );

    pst_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (fr_vld),
        .in_rdy   (fr_rdy),
        .in_item  (fr_item),
        .out_vld  (q_vld),
        .out_rdy  (q_rdy),
        .out_item (q_item)
    );

    pst_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_vld   (q_vld),
        .q_rdy   (q_rdy),
        .q_item  (q_item),
        .res_vld (m_tvalid),
        .res_rdy (m_tready),
        .res     (res)
    );

    assign m_tdata = {4'b0000, res.ovf, res.writeback_cycle, res.memory_cycle,
                      res.execute_cycle, res.decode_cycle, res.fetch_cycle, res.cls};

endmodule

// File: hdl/pst_ram.sv
`timescale 1ns / 1ps
module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/pst_front.sv
`timescale 1ns / 1ps
module pst_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_vld,
    output logic           in_rdy,
    input  logic [31:0]    instr_word,
    output logic           out_vld,
    input  logic           out_rdy,
    output pst_pkg::item_t out_item
);
    import pst_pkg::*;

    logic  vld_reg, vld_next;
    item_t item_reg, item_next;
    item_t dec;
    logic  load;

    logic [IDX_W-1:0] rd, rs1, rs2;

    assign rd  = instr_word[11:7];
    assign rs1 = instr_word[19:15];
    assign rs2 = instr_word[24:20];

    always_comb
    begin
        dec       = '0;
        dec.rd    = rd;
        dec.src_a = rs1;
        dec.src_b = rs2;
        unique case (instr_word[6:0])
            OP_R:
            begin
                dec.cls = CL_R;  dec.wait_a = 1'b1; dec.wait_b = 1'b1; dec.wr = 1'b1;
            end
            OP_I:
            begin
                dec.cls = CL_I;  dec.wait_a = 1'b1; dec.wr = 1'b1;
            end
            OP_LOAD:
            begin
                dec.cls = CL_LOAD; dec.wait_a = 1'b1; dec.wr = 1'b1;
            end
            OP_STORE:
            begin
                // data register gates EXE, base register gates MEM
                dec.cls    = CL_STORE;
                dec.src_a  = rs2;
                dec.src_b  = rs1;
                dec.wait_a = 1'b1;
                dec.wait_m = 1'b1;
            end
            OP_BRANCH:
            begin
                dec.cls = CL_BRANCH; dec.wait_a = 1'b1; dec.wait_b = 1'b1;
            end
            OP_LUI:
            begin
                dec.cls = CL_LUI; dec.wr = 1'b1;
            end
            OP_AUIPC:
            begin
                dec.cls = CL_AUIPC; dec.wr = 1'b1;
            end
            default:
            begin
                dec.cls = CL_UNKNOWN;
            end
        endcase
    end

    assign in_rdy = !vld_reg || out_rdy;
    assign load   = in_vld && in_rdy;

    always_comb
    begin
        vld_next  = vld_reg;
        item_next = item_reg;
        if (load)
        begin
            vld_next  = 1'b1;
            item_next = dec;
        end
        else if (out_rdy)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

// File: hdl/pst_fifo.sv
`timescale 1ns / 1ps
`include "pipeline_stall_timing_scoreboard_assert.svh"
module pst_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_vld,
    output logic           in_rdy,
    input  pst_pkg::item_t in_item,
    output logic           out_vld,
    input  logic           out_rdy,
    output pst_pkg::item_t out_item
);
    import pst_pkg::*;

    localparam logic [Q_AW:0]   FULL = (Q_AW + 1)'(Q_DEPTH);
    localparam logic [Q_AW-1:0] LAST = Q_AW'(Q_DEPTH - 1);

    item_t           mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wptr_reg, wptr_next;
    logic [Q_AW-1:0] rptr_reg, rptr_next;
    logic [Q_AW:0]   count_reg, count_next;
    logic            push, pop;

    assign in_rdy   = (count_reg != FULL);
    assign out_vld  = (count_reg != '0);
    assign out_item = mem_reg[rptr_reg];
    assign push     = in_vld && in_rdy;
    assign pop      = out_vld && out_rdy;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == LAST) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == LAST) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    `PST_ASSERT(a_q_count, 1'b1, count_reg <= FULL, "queue count above depth")

endmodule

// File: hdl/pst_back.sv
`timescale 1ns / 1ps
`include "pipeline_stall_timing_scoreboard_assert.svh"
module pst_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_vld,
    output logic             q_rdy,
    input  pst_pkg::item_t   q_item,
    output logic             res_vld,
    input  logic             res_rdy,
    output pst_pkg::result_t res
);
    import pst_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_EX1  = 3'd2;
    localparam logic [2:0] S_EX2  = 3'd3;
    localparam logic [2:0] S_MEM  = 3'd4;
    localparam logic [2:0] S_WB   = 3'd5;

    function automatic sat_t cyc_inc(cycle_t x);
        sat_t r;
        r.ovf = (x == CYC_MAX);
        r.val = r.ovf ? x : x + CYCLE_BITS'(1);
        return r;
    endfunction

    function automatic sat_t wait_on(cycle_t c, cycle_t b);
        sat_t r;
        sat_t bi;
        bi = cyc_inc(b);
        if (b >= c)
        begin
            r = bi;
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = c;
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] to_out(cycle_t c);
        logic [63:0] x;
        x = 64'(c);
        return x[OUT_W-1:0];
    endfunction

    function automatic logic in_range(logic [IDX_W-1:0] idx);
        return ({1'b0, idx} < (IDX_W + 1)'(REG_COUNT));
    endfunction

    logic [2:0] state_reg, state_next;
    item_t      item_reg, item_next;
    cycle_t     f_reg, f_next, d_reg, d_next, c_reg, c_next;
    cycle_t     e_reg, e_next, m_reg, m_next;
    cycle_t     last_f_reg, last_d_reg, last_e_reg, last_m_reg, last_w_reg;
    cycle_t     wb_val;
    logic       ovf_reg, ovf_next;
    logic       res_vld_reg, res_vld_next;
    result_t    res_reg, res_next;
    logic       wb_go;

    logic [REG_COUNT-1:0] vld_reg;
    logic                 hit_reg;
    logic                 re, we;
    logic [IDX_W-1:0]     ridx;
    logic [REG_AW-1:0]    raddr, waddr;
    cycle_t               rdata, busy;

    // jump over the previous item's stall cycles
    function automatic cycle_t skip_stall(cycle_t c, cycle_t s0, cycle_t s1, cycle_t s2,
                                          cycle_t s3, cycle_t s4);
        cycle_t s [5];
        cycle_t r;
        logic   hit;
        s[0] = s0; s[1] = s1; s[2] = s2; s[3] = s3; s[4] = s4;
        r    = c;
        hit  = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (!hit && c > s[k] && c < s[k+1])
            begin
                r   = s[k+1];
                hit = 1'b1;
            end
        end
        return r;
    endfunction

    assign busy  = hit_reg ? rdata : '0;
    assign re    = (state_reg == S_DEC) || (state_reg == S_EX1);
    assign ridx  = (state_reg == S_DEC) ? item_reg.src_a : item_reg.src_b;
    assign raddr = ridx[REG_AW-1:0];
    assign wb_go = (state_reg == S_WB) && (!res_vld_reg || res_rdy);
    assign we    = wb_go && item_reg.wr && in_range(item_reg.rd);
    assign waddr = item_reg.rd[REG_AW-1:0];
    assign q_rdy = (state_reg == S_IDLE);

    always_comb
    begin : seq_comb
        sat_t t;
        sat_t w;
        state_next   = state_reg;
        item_next    = item_reg;
        f_next       = f_reg;
        d_next       = d_reg;
        c_next       = c_reg;
        e_next       = e_reg;
        m_next       = m_reg;
        ovf_next     = ovf_reg;
        res_vld_next = res_vld_reg;
        res_next     = res_reg;
        wb_val       = '0;
        t            = '0;
        w            = '0;
        if (res_vld_reg && res_rdy)
        begin
            res_vld_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_vld)
                begin
                    t          = cyc_inc(last_f_reg);
                    f_next     = skip_stall(t.val, last_f_reg, last_d_reg, last_e_reg,
                                            last_m_reg, last_w_reg);
                    ovf_next   = t.ovf;
                    item_next  = q_item;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                t          = cyc_inc(f_reg);
                d_next     = skip_stall(t.val, last_f_reg, last_d_reg, last_e_reg,
                                        last_m_reg, last_w_reg);
                ovf_next   = ovf_reg | t.ovf;
                state_next = S_EX1;
            end
            S_EX1:
            begin
                t = cyc_inc(d_reg);
                w = item_reg.wait_a ? wait_on(t.val, busy) : t;
                if (!item_reg.wait_a)
                begin
                    w.ovf = 1'b0;
                end
                c_next     = w.val;
                ovf_next   = ovf_reg | t.ovf | w.ovf;
                state_next = S_EX2;
            end
            S_EX2:
            begin
                w = wait_on(c_reg, busy);
                if (!item_reg.wait_b)
                begin
                    w.val = c_reg;
                    w.ovf = 1'b0;
                end
                e_next     = skip_stall(w.val, last_f_reg, last_d_reg, last_e_reg,
                                        last_m_reg, last_w_reg);
                ovf_next   = ovf_reg | w.ovf;
                state_next = S_MEM;
            end
            S_MEM:
            begin
                t = cyc_inc(e_reg);
                w = wait_on(t.val, busy);
                if (!item_reg.wait_m)
                begin
                    w.val = t.val;
                    w.ovf = 1'b0;
                end
                m_next     = skip_stall(w.val, last_f_reg, last_d_reg, last_e_reg,
                                        last_m_reg, last_w_reg);
                ovf_next   = ovf_reg | t.ovf | w.ovf;
                state_next = S_WB;
            end
            S_WB:
            begin
                t      = cyc_inc(m_reg);
                wb_val = skip_stall(t.val, last_f_reg, last_d_reg, last_e_reg,
                                    last_m_reg, last_w_reg);
                if (wb_go)
                begin
                    res_vld_next             = 1'b1;
                    res_next.cls             = item_reg.cls;
                    res_next.fetch_cycle     = to_out(f_reg);
                    res_next.decode_cycle    = to_out(d_reg);
                    res_next.execute_cycle   = to_out(e_reg);
                    res_next.memory_cycle    = to_out(m_reg);
                    res_next.writeback_cycle = to_out(wb_val);
                    res_next.ovf             = ovf_reg | t.ovf;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            res_vld_reg <= 1'b0;
            vld_reg     <= '0;
            last_f_reg  <= '0;
            last_d_reg  <= '0;
            last_e_reg  <= '0;
            last_m_reg  <= '0;
            last_w_reg  <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            res_vld_reg <= res_vld_next;
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                hit_reg <= in_range(ridx) && vld_reg[raddr];
            end
            if (wb_go)
            begin
                last_f_reg <= f_reg;
                last_d_reg <= d_reg;
                last_e_reg <= e_reg;
                last_m_reg <= m_reg;
                last_w_reg <= wb_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        f_reg    <= f_next;
        d_reg    <= d_next;
        c_reg    <= c_next;
        e_reg    <= e_next;
        m_reg    <= m_next;
        ovf_reg  <= ovf_next;
        res_reg  <= res_next;
    end

    pst_ram #(
        .WIDTH (CYCLE_BITS),
        .DEPTH (REG_COUNT)
    ) u_busy_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wb_val),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign res_vld = res_vld_reg;
    assign res     = res_reg;

    `PST_ASSERT(a_stage_order, state_reg == S_WB,
        d_reg >= f_reg && e_reg >= d_reg && m_reg >= e_reg, "stage cycles out of order")
    `PST_ASSERT_NXT(a_wb_hold, state_reg == S_WB && res_vld_reg && !res_rdy,
        state_reg == S_WB, "writeback left while result pending")
    `PST_ASSERT_NXT(a_fetch_adv, state_reg == S_IDLE && q_vld && last_f_reg != CYC_MAX,
        f_reg > $past(last_f_reg), "fetch did not advance")

endmodule
